>>> hdl/regalloc_pkg.sv
// Shared types and codes for the register allocator with symbol binding.
// No dependencies; the interfaces, the scanner, the top level and the bench import this package.
package regalloc_pkg;

	// Default sizes of the register table
	localparam int NUM_REGS_DEF    = 8;
	localparam int SYMBOL_BITS_DEF = 16;

	// Fixed field widths of the request and response channels
	localparam int OP_W   = 2;
	localparam int SYM_W  = 16;
	localparam int KIND_W = 2;
	localparam int VAL_W  = 16;
	localparam int REG_W  = 3;
	localparam int OUTK_W = 2;

	// Request opcodes
	localparam logic [OP_W-1:0] OP_GET_FREE = 2'd0;
	localparam logic [OP_W-1:0] OP_GET_SYM  = 2'd1;
	localparam logic [OP_W-1:0] OP_ASSIGN   = 2'd2;
	localparam logic [OP_W-1:0] OP_FREE     = 2'd3;

	// Symbol kinds
	localparam logic [KIND_W-1:0] KIND_CONST = 2'd1;
	localparam logic [KIND_W-1:0] KIND_VAR   = 2'd2;

	// Response kinds
	localparam logic [OUTK_W-1:0] OUT_ANSWER = 2'd0;
	localparam logic [OUTK_W-1:0] OUT_LDI    = 2'd1;
	localparam logic [OUTK_W-1:0] OUT_LDIND  = 2'd2;
	localparam logic [OUTK_W-1:0] OUT_FULL   = 2'd3;

	// One response line
	typedef struct packed {
		logic [OUTK_W-1:0] kind;
		logic [REG_W-1:0]  dest;
		logic [REG_W-1:0]  src;
		logic [VAL_W-1:0]  imm;
		logic              last;
	} res_t;

	// Status handed from the table scanner to the sequencer
	typedef struct packed {
		logic done;
		logic hit;
		logic free0_ok;
		logic free1_ok;
	} scan_flags_t;

endpackage

>>> hdl/regalloc_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on regalloc_pkg for field widths.
interface regalloc_in_if import regalloc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   opcode;
	logic [SYM_W-1:0]  symbol_id;
	logic [KIND_W-1:0] symbol_kind;
	logic [VAL_W-1:0]  symbol_value;
	logic [REG_W-1:0]  reg_number;

	modport source (output valid, opcode, symbol_id, symbol_kind, symbol_value, reg_number,
		input ready);
	modport sink (input valid, opcode, symbol_id, symbol_kind, symbol_value, reg_number,
		output ready);
endinterface

interface regalloc_out_if import regalloc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OUTK_W-1:0] out_kind;
	logic [REG_W-1:0]  dest_reg;
	logic [REG_W-1:0]  src_reg;
	logic [VAL_W-1:0]  immediate;
	logic              last;

	modport source (output valid, out_kind, dest_reg, src_reg, immediate, last, input ready);
	modport sink (input valid, out_kind, dest_reg, src_reg, immediate, last, output ready);
endinterface

>>> hdl/regalloc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module regalloc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hdl/regalloc_scan.sv
// Table scanner: walks the register table one entry a cycle through the symbol RAM,
// with one shared symbol comparator; finds the lowest hit and the two lowest free entries.
// Depends on regalloc_pkg.
module regalloc_scan import regalloc_pkg::*; #(
	parameter int NUM_REGS = NUM_REGS_DEF,
	parameter int SW = SYMBOL_BITS_DEF,
	localparam int RW = $clog2(NUM_REGS)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [SW-1:0]       symbol,
	input  logic [NUM_REGS-1:0] allocated,
	input  logic [NUM_REGS-1:0] bound,
	output logic [RW-1:0]       rd_addr,
	input  logic [SW-1:0]       rd_data,
	output scan_flags_t         flags,
	output logic [RW-1:0]       hit_idx,
	output logic [RW-1:0]       free0_idx,
	output logic [RW-1:0]       free1_idx
);

	localparam logic [RW-1:0] LAST = RW'(NUM_REGS - 1);

	logic          busy_q;
	logic [RW-1:0] idx_q;
	logic          valid_s1;
	logic          last_s1;
	logic [RW-1:0] idx_s1;
	logic          hit_q;
	logic          f0ok_q;
	logic          f1ok_q;
	logic          done_q;
	logic [RW-1:0] hit_idx_q;
	logic [RW-1:0] f0_q;
	logic [RW-1:0] f1_q;
	logic          match;
	logic          is_free;

	assign rd_addr = idx_q;

	// Shared comparator on the entry whose symbol is coming out of the RAM
	assign match   = allocated[idx_s1] && bound[idx_s1] && (rd_data == symbol);
	assign is_free = !allocated[idx_s1];

	// Scan control and result flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
			done_q   <= 1'b0;
			hit_q    <= 1'b0;
			f0ok_q   <= 1'b0;
			f1ok_q   <= 1'b0;
		end else begin
			done_q   <= valid_s1 && last_s1;
			valid_s1 <= busy_q;
			last_s1  <= busy_q && (idx_q == LAST);
			if (start) begin
				busy_q <= 1'b1;
				hit_q  <= 1'b0;
				f0ok_q <= 1'b0;
				f1ok_q <= 1'b0;
			end else begin
				if (busy_q && (idx_q == LAST)) begin
					busy_q <= 1'b0;
				end
				if (valid_s1) begin
					if (match) begin
						hit_q <= 1'b1;
					end
					if (is_free) begin
						if (!f0ok_q) begin
							f0ok_q <= 1'b1;
						end else begin
							f1ok_q <= 1'b1;
						end
					end
				end
			end
		end
	end

	// Entry counter and captured indexes
	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		if (start) begin
			idx_q <= '0;
		end else begin
			if (busy_q) begin
				idx_q <= idx_q + RW'(1);
			end
			if (valid_s1) begin
				if (match && !hit_q) begin
					hit_idx_q <= idx_s1;
				end
				if (is_free) begin
					if (!f0ok_q) begin
						f0_q <= idx_s1;
					end else if (!f1ok_q) begin
						f1_q <= idx_s1;
					end
				end
			end
		end
	end

	assign flags.done     = done_q;
	assign flags.hit      = hit_q;
	assign flags.free0_ok = f0ok_q;
	assign flags.free1_ok = f1ok_q;
	assign hit_idx        = hit_idx_q;
	assign free0_idx      = f0_q;
	assign free1_idx      = f1_q;

endmodule

>>> hdl/register_allocator_with_binding_top.sv
// Register allocator with symbol binding: top level with request sequencer.
// Depends on regalloc_pkg, regalloc_if, regalloc_ram and regalloc_scan.
//
// Requests arrive on req (valid/ready) and carry an opcode: get free, get for
// symbol, assign or free. Responses leave on rsp (valid/ready), one line per
// transfer, with last set on the final line of a request.
// Assign and free take effect on their transfer and produce no response.
// Get free and get for symbol run a scan of the register table: the scanner reads
// the symbol RAM one entry a cycle through a single comparator, and the response
// lines are built when the scan is done. Up to three lines are sent, one per
// cycle while rsp is ready.
// req.ready is high only while no request is in progress, so the next request
// is not taken before the last line of the current one has gone out; a stalled
// receiver simply holds the current line and the next request waits.
// Reset clears the allocated and bound marks at once; the symbol RAM is not
// cleared, as an entry is only looked at while its bound mark is set.
module register_allocator_with_binding_top import regalloc_pkg::*; #(
	parameter int NUM_REGS = NUM_REGS_DEF,
	parameter int SYMBOL_BITS = SYMBOL_BITS_DEF
) (
	input logic             clk,
	input logic             arst_n,
	regalloc_in_if.sink     req,
	regalloc_out_if.source  rsp
);

	localparam int RW = $clog2(NUM_REGS);
	localparam int SW = (SYMBOL_BITS < SYM_W) ? SYMBOL_BITS : SYM_W;

	// Sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]          state_q;
	logic [OP_W-1:0]     op_q;
	logic [SW-1:0]       sym_q;
	logic [KIND_W-1:0]   kind_q;
	logic [VAL_W-1:0]    val_q;
	logic [NUM_REGS-1:0] alloc_q;
	logic [NUM_REGS-1:0] bound_q;
	res_t                res_q [3];
	logic [1:0]          ptr_q;
	logic [1:0]          last_idx_q;

	logic                accept;
	logic                scan_start;
	logic [RW-1:0]       reg_idx;
	logic                reg_ok;
	logic [RW-1:0]       rd_addr;
	logic [SW-1:0]       rd_data;
	scan_flags_t         flags;
	logic [RW-1:0]       hit_idx;
	logic [RW-1:0]       f0_idx;
	logic [RW-1:0]       f1_idx;
	logic                ram_we;
	logic [RW-1:0]       ram_waddr;
	logic [SW-1:0]       ram_wdata;
	logic                decide;
	logic                sym_mode;
	res_t                dec_res [3];
	logic [1:0]          dec_last;
	logic                dec_take;
	logic                dec_bind;
	logic                rsp_xfer;

	assign req.ready  = (state_q == ST_IDLE);
	assign accept     = req.valid && req.ready;
	assign scan_start = accept && ((req.opcode == OP_GET_FREE) || (req.opcode == OP_GET_SYM));
	assign reg_idx    = RW'(req.reg_number);
	assign reg_ok     = int'(req.reg_number) < NUM_REGS;
	assign decide     = (state_q == ST_SCAN) && flags.done;
	assign sym_mode   = (op_q == OP_GET_SYM) && ((kind_q == KIND_CONST) || (kind_q == KIND_VAR));
	assign rsp_xfer   = rsp.valid && rsp.ready;

	// Symbol RAM: assign writes the incoming symbol, a binding get the captured one
	assign ram_we    = (accept && (req.opcode == OP_ASSIGN) && reg_ok && alloc_q[reg_idx]) ||
		(decide && dec_take && dec_bind);
	assign ram_waddr = decide ? f0_idx : reg_idx;
	assign ram_wdata = decide ? sym_q : req.symbol_id[SW-1:0];

	regalloc_ram #(
		.WIDTH(SW),
		.DEPTH(NUM_REGS)
	) u_sym_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	regalloc_scan #(
		.NUM_REGS(NUM_REGS),
		.SW(SW)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (scan_start),
		.symbol   (sym_q),
		.allocated(alloc_q),
		.bound    (bound_q),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.flags    (flags),
		.hit_idx  (hit_idx),
		.free0_idx(f0_idx),
		.free1_idx(f1_idx)
	);

	// Outcome of a finished scan: response lines and table update
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dec_res[i] = '{kind: OUT_FULL, dest: '0, src: '0, imm: '0, last: 1'b1};
		end
		dec_last = 2'd0;
		dec_take = 1'b0;
		dec_bind = 1'b0;
		if (!sym_mode) begin
			if (flags.free0_ok) begin
				dec_take   = 1'b1;
				dec_res[0] = '{kind: OUT_ANSWER, dest: REG_W'(f0_idx), src: '0, imm: '0,
					last: 1'b1};
			end
		end else if (flags.hit) begin
			dec_res[0] = '{kind: OUT_ANSWER, dest: REG_W'(hit_idx), src: '0, imm: '0,
				last: 1'b1};
		end else if (flags.free0_ok) begin
			if (kind_q == KIND_CONST) begin
				dec_take   = 1'b1;
				dec_bind   = 1'b1;
				dec_last   = 2'd1;
				dec_res[0] = '{kind: OUT_LDI, dest: REG_W'(f0_idx), src: '0, imm: val_q,
					last: 1'b0};
				dec_res[1] = '{kind: OUT_ANSWER, dest: REG_W'(f0_idx), src: '0, imm: '0,
					last: 1'b1};
			end else if (flags.free1_ok) begin
				// variable: scratch register takes the address, then indirect load
				dec_take   = 1'b1;
				dec_bind   = 1'b1;
				dec_last   = 2'd2;
				dec_res[0] = '{kind: OUT_LDI, dest: REG_W'(f1_idx), src: '0, imm: val_q,
					last: 1'b0};
				dec_res[1] = '{kind: OUT_LDIND, dest: REG_W'(f0_idx), src: REG_W'(f1_idx),
					imm: '0, last: 1'b0};
				dec_res[2] = '{kind: OUT_ANSWER, dest: REG_W'(f0_idx), src: '0, imm: '0,
					last: 1'b1};
			end
		end
	end

	// Sequencer and table marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			alloc_q    <= '0;
			bound_q    <= '0;
			ptr_q      <= 2'd0;
			last_idx_q <= 2'd0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (scan_start) begin
							state_q <= ST_SCAN;
						end else if (reg_ok) begin
							if (req.opcode == OP_ASSIGN) begin
								if (alloc_q[reg_idx]) begin
									bound_q[reg_idx] <= 1'b1;
								end
							end else begin
								alloc_q[reg_idx] <= 1'b0;
								bound_q[reg_idx] <= 1'b0;
							end
						end
					end
				end
				ST_SCAN: begin
					if (decide) begin
						state_q    <= ST_EMIT;
						ptr_q      <= 2'd0;
						last_idx_q <= dec_last;
						if (dec_take) begin
							alloc_q[f0_idx] <= 1'b1;
							bound_q[f0_idx] <= dec_bind;
						end
					end
				end
				ST_EMIT: begin
					if (rsp_xfer) begin
						if (ptr_q == last_idx_q) begin
							state_q <= ST_IDLE;
						end else begin
							ptr_q <= ptr_q + 2'd1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request capture and response lines
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= req.opcode;
			sym_q  <= req.symbol_id[SW-1:0];
			kind_q <= req.symbol_kind;
			val_q  <= req.symbol_value;
		end
		if (decide) begin
			for (int i = 0; i < 3; i++) begin
				res_q[i] <= dec_res[i];
			end
		end
	end

	assign rsp.valid     = (state_q == ST_EMIT);
	assign rsp.out_kind  = res_q[ptr_q].kind;
	assign rsp.dest_reg  = res_q[ptr_q].dest;
	assign rsp.src_reg   = res_q[ptr_q].src;
	assign rsp.immediate = res_q[ptr_q].imm;
	assign rsp.last      = res_q[ptr_q].last;

endmodule

>>> bench/register_allocator_with_binding_top_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the register allocator with symbol binding.
// Uses regalloc_pkg, regalloc_if and the top level; a directed table then random requests.
module register_allocator_with_binding_top_tb;
	import regalloc_pkg::*;

	localparam int NUM_REGS    = NUM_REGS_DEF;
	localparam int SYMBOL_BITS = SYMBOL_BITS_DEF;
	localparam int LINE_LAT    = NUM_REGS + 6;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RAND_ITEMS  = 150;
	localparam logic [SYM_W-1:0] SYM_MASK = SYM_W'((64'd1 << SYMBOL_BITS) - 1);

	// Symbol kinds that fall back to a plain get free
	localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_BAD  = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [SYM_W-1:0]  sym;
		logic [KIND_W-1:0] kind;
		logic [VAL_W-1:0]  val;
		logic [REG_W-1:0]  rnum;
	} req_t;

	typedef struct packed {
		req_t rq;
		bit   typed;
		res_t want;
	} dir_row_t;

	logic clk;
	logic arst_n;
	bit   quiet_run;
	int   errors;
	int   cycle_cnt;

	// Shadow register table
	bit               alloc_mark[NUM_REGS];
	bit               bind_mark[NUM_REGS];
	logic [SYM_W-1:0] bind_sym[NUM_REGS];

	res_t             expected_lines[$];
	dir_row_t         dir_tab[$];
	logic [SYM_W-1:0] sym_pool[8];

	regalloc_in_if  req_if ();
	regalloc_out_if rsp_if ();

	register_allocator_with_binding_top #(
		.NUM_REGS   (NUM_REGS),
		.SYMBOL_BITS(SYMBOL_BITS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_if),
		.rsp   (rsp_if)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic res_t mk_line(logic [OUTK_W-1:0] kind, int dest, int src,
			logic [VAL_W-1:0] imm, logic last);
		res_t l;
		l.kind = kind;
		l.dest = REG_W'(dest);
		l.src  = REG_W'(src);
		l.imm  = imm;
		l.last = last;
		return l;
	endfunction

	function automatic dir_row_t mk_row(logic [OP_W-1:0] op, logic [SYM_W-1:0] sym,
			logic [KIND_W-1:0] kind, logic [VAL_W-1:0] val, logic [REG_W-1:0] rnum,
			bit typed, logic [OUTK_W-1:0] okind, int odest);
		dir_row_t d;
		d.rq    = '{op: op, sym: sym, kind: kind, val: val, rnum: rnum};
		d.typed = typed;
		d.want  = mk_line(okind, odest, 0, '0, 1'b1);
		return d;
	endfunction

	function automatic int lowest_unalloc();
		for (int i = 0; i < NUM_REGS; i++)
			if (!alloc_mark[i])
				return i;
		return -1;
	endfunction

	function automatic int alloc_count();
		int n;
		n = 0;
		for (int i = 0; i < NUM_REGS; i++)
			n += alloc_mark[i];
		return n;
	endfunction

	// Plain allocation of the lowest free register
	function automatic res_t take_free();
		int r;
		r = lowest_unalloc();
		if (r < 0)
			return mk_line(OUT_FULL, 0, 0, '0, 1'b1);
		alloc_mark[r] = 1'b1;
		bind_mark[r]  = 1'b0;
		return mk_line(OUT_ANSWER, r, 0, '0, 1'b1);
	endfunction

	// Applies one request to the shadow table and returns the response lines it causes
	function automatic int predict_lines(input req_t rq, output res_t lines[3]);
		logic [SYM_W-1:0] sym;
		int hit, r, a, n;
		sym = rq.sym & SYM_MASK;
		hit = -1;
		n = 0;
		for (int i = 0; i < 3; i++)
			lines[i] = '0;
		case (rq.op)
			OP_GET_FREE: begin
				lines[0] = take_free();
				n = 1;
			end
			OP_GET_SYM: begin
				if (rq.kind != KIND_CONST && rq.kind != KIND_VAR) begin
					lines[0] = take_free();
					n = 1;
				end else begin
					for (int i = 0; i < NUM_REGS && hit < 0; i++)
						if (alloc_mark[i] && bind_mark[i] && bind_sym[i] == sym)
							hit = i;
					r = lowest_unalloc();
					if (hit >= 0) begin
						lines[0] = mk_line(OUT_ANSWER, hit, 0, '0, 1'b1);
						n = 1;
					end else if (r < 0) begin
						lines[0] = mk_line(OUT_FULL, 0, 0, '0, 1'b1);
						n = 1;
					end else if (rq.kind == KIND_CONST) begin
						alloc_mark[r] = 1'b1;
						bind_mark[r]  = 1'b1;
						bind_sym[r]   = sym;
						lines[0] = mk_line(OUT_LDI, r, 0, rq.val, 1'b0);
						lines[1] = mk_line(OUT_ANSWER, r, 0, '0, 1'b1);
						n = 2;
					end else begin
						alloc_mark[r] = 1'b1;
						a = lowest_unalloc();
						if (a < 0) begin
							// no scratch register: give the value register back
							alloc_mark[r] = 1'b0;
							bind_mark[r]  = 1'b0;
							lines[0] = mk_line(OUT_FULL, 0, 0, '0, 1'b1);
							n = 1;
						end else begin
							lines[0] = mk_line(OUT_LDI, a, 0, rq.val, 1'b0);
							lines[1] = mk_line(OUT_LDIND, r, a, '0, 1'b0);
							lines[2] = mk_line(OUT_ANSWER, r, 0, '0, 1'b1);
							alloc_mark[a] = 1'b0;
							bind_mark[a]  = 1'b0;
							bind_mark[r]  = 1'b1;
							bind_sym[r]   = sym;
							n = 3;
						end
					end
				end
			end
			OP_ASSIGN: begin
				if (rq.rnum < NUM_REGS && alloc_mark[rq.rnum]) begin
					bind_mark[rq.rnum] = 1'b1;
					bind_sym[rq.rnum]  = sym;
				end
			end
			default: begin
				if (rq.rnum < NUM_REGS) begin
					alloc_mark[rq.rnum] = 1'b0;
					bind_mark[rq.rnum]  = 1'b0;
				end
			end
		endcase
		return n;
	endfunction

	function automatic logic [SYM_W-1:0] pick_sym();
		if ($urandom_range(99) < 75)
			return sym_pool[$urandom_range(7)];
		return SYM_W'($urandom());
	endfunction

	// Random request, weighted towards frees when the table fills up
	function automatic req_t rand_req(output bit effective);
		req_t rq;
		int   pick, k;
		rq.sym  = pick_sym();
		rq.val  = VAL_W'($urandom());
		rq.rnum = REG_W'($urandom_range(NUM_REGS - 1));
		rq.kind = KIND_W'($urandom_range(3));
		pick = $urandom_range(99);
		if (alloc_count() >= 6 && pick < 40)
			rq.op = OP_FREE;
		else if (pick < 15)
			rq.op = OP_GET_FREE;
		else if (pick < 55)
			rq.op = OP_GET_SYM;
		else if (pick < 72)
			rq.op = OP_ASSIGN;
		else
			rq.op = OP_FREE;
		if (rq.op == OP_GET_SYM) begin
			k = $urandom_range(99);
			rq.kind = (k < 45) ? KIND_CONST : (k < 90) ? KIND_VAR : rq.kind;
		end
		// mostly aim assign and free at a live register
		if ((rq.op == OP_ASSIGN || rq.op == OP_FREE) && alloc_count() != 0 &&
				$urandom_range(99) < 70)
			while (!alloc_mark[rq.rnum])
				rq.rnum = REG_W'($urandom_range(NUM_REGS - 1));
		effective = !((rq.op == OP_ASSIGN || rq.op == OP_FREE) && !alloc_mark[rq.rnum]);
		return rq;
	endfunction

	// Drive one request from a falling edge, wait for its transfer, log the expectation
	task automatic send_req(input req_t rq, input bit typed, input res_t want);
		res_t lines[3];
		int   n;
		while (!quiet_run && $urandom_range(99) < 28) begin
			req_if.valid <= 1'b0;
			@(negedge clk);
		end
		req_if.valid        <= 1'b1;
		req_if.opcode       <= rq.op;
		req_if.symbol_id    <= rq.sym;
		req_if.symbol_kind  <= rq.kind;
		req_if.symbol_value <= rq.val;
		req_if.reg_number   <= rq.rnum;
		do @(posedge clk); while (!req_if.ready);
		n = predict_lines(rq, lines);
		if (typed)
			expected_lines.push_back(want);
		else
			for (int i = 0; i < n; i++)
				expected_lines.push_back(lines[i]);
		@(negedge clk);
	endtask

	// Receiver back-pressure
	always @(negedge clk)
		rsp_if.ready <= quiet_run || ($urandom_range(99) >= 28);

	// Response check against the oldest expectation
	always @(posedge clk) begin
		res_t got, want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			got = mk_line(rsp_if.out_kind, rsp_if.dest_reg, rsp_if.src_reg,
				rsp_if.immediate, rsp_if.last);
			if (expected_lines.size() == 0) begin
				errors++;
				$display("%0t: unexpected line kind=%0d dest=%0d src=%0d imm=%h last=%0d",
					$realtime, got.kind, got.dest, got.src, got.imm, got.last);
			end else begin
				want = expected_lines.pop_front();
				if (got !== want) begin
					errors++;
					$display("%0t: mismatch exp kind=%0d dest=%0d src=%0d imm=%h last=%0d",
						$realtime, want.kind, want.dest, want.src, want.imm, want.last);
					$display("%0t:          got kind=%0d dest=%0d src=%0d imm=%h last=%0d",
						$realtime, got.kind, got.dest, got.src, got.imm, got.last);
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		req_t rq;
		bit   effective;
		int   n_rand;
		arst_n              = 1'b0;
		quiet_run           = 1'b0;
		errors              = 0;
		cycle_cnt           = 0;
		req_if.valid        = 1'b0;
		req_if.opcode       = OP_GET_FREE;
		req_if.symbol_id    = '0;
		req_if.symbol_kind  = KIND_NONE;
		req_if.symbol_value = '0;
		req_if.reg_number   = '0;
		rsp_if.ready        = 1'b0;
		for (int i = 0; i < NUM_REGS; i++) begin
			alloc_mark[i] = 1'b0;
			bind_mark[i]  = 1'b0;
			bind_sym[i]   = '0;
		end
		sym_pool[0] = 16'h0000;
		sym_pool[1] = 16'hFFFF;
		for (int i = 2; i < 8; i++)
			sym_pool[i] = SYM_W'($urandom());

		// Directed table: typed rows are simple answers and table-full codes
		dir_tab.push_back(mk_row(OP_GET_FREE, 16'h0000, KIND_NONE, 16'h0000, 3'd0, 1, OUT_ANSWER, 0));
		dir_tab.push_back(mk_row(OP_GET_SYM, 16'hFFFF, KIND_CONST, 16'hFFFF, 3'd0, 0, OUT_ANSWER, 0));
		dir_tab.push_back(mk_row(OP_GET_SYM, 16'hFFFF, KIND_VAR, 16'h0000, 3'd0, 1, OUT_ANSWER, 1));
		dir_tab.push_back(mk_row(OP_GET_SYM, 16'h0000, KIND_VAR, 16'hA5A5, 3'd7, 0, OUT_ANSWER, 0));
		dir_tab.push_back(mk_row(OP_ASSIGN, 16'h1234, KIND_NONE, 16'h0000, 3'd0, 0, OUT_ANSWER, 0));
		dir_tab.push_back(mk_row(OP_GET_SYM, 16'h1234, KIND_CONST, 16'h0000, 3'd0, 1, OUT_ANSWER, 0));
		// assign to a register nobody holds
		dir_tab.push_back(mk_row(OP_ASSIGN, 16'h5555, KIND_NONE, 16'h0000, 3'd5, 0, OUT_ANSWER, 0));
		// no-symbol kinds fall back to get free
		dir_tab.push_back(mk_row(OP_GET_SYM, 16'h5555, KIND_NONE, 16'h0000, 3'd0, 1, OUT_ANSWER, 3));
		dir_tab.push_back(mk_row(OP_GET_SYM, 16'h5555, KIND_BAD, 16'hFFFF, 3'd0, 1, OUT_ANSWER, 4));
		// two registers on one symbol, lowest wins, then rebinding
		dir_tab.push_back(mk_row(OP_ASSIGN, 16'hFFFF, KIND_NONE, 16'h0000, 3'd4, 0, OUT_ANSWER, 0));
		dir_tab.push_back(mk_row(OP_GET_SYM, 16'hFFFF, KIND_CONST, 16'h0000, 3'd0, 1, OUT_ANSWER, 1));
		dir_tab.push_back(mk_row(OP_ASSIGN, 16'h0001, KIND_NONE, 16'h0000, 3'd1, 0, OUT_ANSWER, 0));
		dir_tab.push_back(mk_row(OP_GET_SYM, 16'hFFFF, KIND_VAR, 16'h0000, 3'd0, 1, OUT_ANSWER, 4));
		dir_tab.push_back(mk_row(OP_FREE, 16'h0000, KIND_NONE, 16'h0000, 3'd7, 0, OUT_ANSWER, 0));
		dir_tab.push_back(mk_row(OP_GET_FREE, 16'h0000, KIND_NONE, 16'h0000, 3'd0, 1, OUT_ANSWER, 5));
		dir_tab.push_back(mk_row(OP_GET_FREE, 16'h0000, KIND_NONE, 16'h0000, 3'd0, 1, OUT_ANSWER, 6));
		// variable miss with no scratch register left
		dir_tab.push_back(mk_row(OP_GET_SYM, 16'h00AA, KIND_VAR, 16'h1111, 3'd0, 1, OUT_FULL, 0));
		dir_tab.push_back(mk_row(OP_GET_SYM, 16'h00BB, KIND_CONST, 16'h8001, 3'd0, 0, OUT_ANSWER, 0));
		dir_tab.push_back(mk_row(OP_GET_FREE, 16'h0000, KIND_NONE, 16'h0000, 3'd0, 1, OUT_FULL, 0));
		dir_tab.push_back(mk_row(OP_GET_SYM, 16'h1234, KIND_VAR, 16'h0000, 3'd0, 1, OUT_ANSWER, 0));
		dir_tab.push_back(mk_row(OP_FREE, 16'h0000, KIND_NONE, 16'h0000, 3'd0, 0, OUT_ANSWER, 0));
		dir_tab.push_back(mk_row(OP_GET_SYM, 16'h1234, KIND_CONST, 16'h0000, 3'd0, 0, OUT_ANSWER, 0));
		dir_tab.push_back(mk_row(OP_FREE, 16'h0000, KIND_NONE, 16'h0000, 3'd7, 0, OUT_ANSWER, 0));
		dir_tab.push_back(mk_row(OP_GET_SYM, 16'h00AA, KIND_VAR, 16'h7FFF, 3'd0, 1, OUT_FULL, 0));
		dir_tab.push_back(mk_row(OP_GET_SYM, 16'h00BB, KIND_CONST, 16'h0F0F, 3'd0, 0, OUT_ANSWER, 0));

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_tab[i])
			send_req(dir_tab[i].rq, dir_tab[i].typed, dir_tab[i].want);

		// Random requests; a quiet stretch in the middle runs without idling
		n_rand = 0;
		while (n_rand < RAND_ITEMS) begin
			quiet_run = (n_rand >= 60 && n_rand < 110);
			rq = rand_req(effective);
			send_req(rq, 1'b0, '0);
			if (effective)
				n_rand++;
		end
		quiet_run = 1'b0;
		req_if.valid <= 1'b0;

		// Drain and let any late line show up
		while (expected_lines.size() != 0)
			@(posedge clk);
		repeat (LINE_LAT) @(posedge clk);
		if (expected_lines.size() != 0) begin
			errors++;
			$display("%0t: %0d expected lines never arrived", $realtime, expected_lines.size());
		end
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> sim.f
hdl/regalloc_pkg.sv
hdl/regalloc_if.sv
hdl/regalloc_ram.sv
hdl/regalloc_scan.sv
hdl/register_allocator_with_binding_top.sv
bench/register_allocator_with_binding_top_tb.sv
